### design/rrps_pkg.sv
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared types and constants of the raster row power run segmenter.
// ----------------------------------------------------------------------------
package rrps_pkg;

    // Row geometry.
    localparam int MAX_ROW_PIXELS = 1024;
    localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
    localparam int CNT_W          = 11;
    localparam int PWR_W          = 8;
    localparam int CFG_IDX_W      = 3;

    // Column marker that means no active column yet.
    localparam logic [CNT_W-1:0] ROW_NONE = CNT_W'(MAX_ROW_PIXELS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_FULL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERPENTINE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

    // Request commands and result kinds.
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_FETCH    = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_SEGMENT = 1'b1;

    // Configuration register file.
    typedef struct packed {
        logic [PWR_W-1:0] pwr_floor;
        logic [PWR_W-1:0] pwr_full;
        logic             binary_mode;
        logic             serpentine_mode;
        logic [PWR_W-1:0] visible_threshold;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic             kind;
        logic             row_empty;
        logic             reverse_dir;
        logic [CNT_W-1:0] start_column;
        logic [CNT_W-1:0] span_pixels;
        logic [PWR_W-1:0] run_power;
        logic             final_segment;
        logic             fault;
    } t_rsp;

endpackage

### design/rrps_ifs.sv
// ----------------------------------------------------------------------------
// rrps channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: pixel loads and segment fetches.
interface rrps_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [rrps_pkg::PWR_W-1:0] pixel;
    logic                      end_of_row;
    logic                      odd_row;

    modport source (output valid, cmd, pixel, end_of_row, odd_row, input ready);
    modport sink   (input valid, cmd, pixel, end_of_row, odd_row, output ready);
endinterface

// Result channel: row summaries and segments.
interface rrps_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic                       row_empty;
    logic                       reverse_dir;
    logic [rrps_pkg::CNT_W-1:0] start_column;
    logic [rrps_pkg::CNT_W-1:0] span_pixels;
    logic [rrps_pkg::PWR_W-1:0] run_power;
    logic                       final_segment;
    logic                       fault;

    modport source (output valid, kind, row_empty, reverse_dir, start_column,
                    span_pixels, run_power, final_segment, fault, input ready);
    modport sink   (input valid, kind, row_empty, reverse_dir, start_column,
                    span_pixels, run_power, final_segment, fault, output ready);
endinterface

// Configuration write channel.
interface rrps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rrps_pkg::CFG_IDX_W-1:0] index;
    logic [rrps_pkg::PWR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/rrps_power_map.sv
// ----------------------------------------------------------------------------
// rrps_power_map
// Two-step pixel to laser power mapping: registered multiply, then the
// divide by 255, offset, binary override and visibility threshold.
// ----------------------------------------------------------------------------
module rrps_power_map (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rrps_pkg::PWR_W-1:0] i_pixel,
    input  rrps_pkg::t_cfg             i_cfg,
    output logic [rrps_pkg::PWR_W-1:0] o_power
);

    logic [rrps_pkg::PWR_W-1:0]   w_lo;
    logic [rrps_pkg::PWR_W-1:0]   w_hi;
    logic [rrps_pkg::PWR_W-1:0]   w_diff;

    logic [2*rrps_pkg::PWR_W-1:0] r_prod;
    logic [rrps_pkg::PWR_W-1:0]   r_lo;
    logic [rrps_pkg::PWR_W-1:0]   r_max;
    logic [rrps_pkg::PWR_W-1:0]   r_thr;
    logic                         r_zero;
    logic                         r_bin;

    logic [2*rrps_pkg::PWR_W:0]   w_q_sum;
    logic [rrps_pkg::PWR_W-1:0]   w_quot;
    logic [rrps_pkg::PWR_W:0]     w_grey;

    // Order the power limits so that the span is never negative.
    assign w_lo   = (i_cfg.pwr_floor < i_cfg.pwr_full) ? i_cfg.pwr_floor : i_cfg.pwr_full;
    assign w_hi   = (i_cfg.pwr_floor < i_cfg.pwr_full) ? i_cfg.pwr_full : i_cfg.pwr_floor;
    assign w_diff = w_hi - w_lo;

    // First step: the product and the mode bits are registered.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{rrps_pkg::PWR_W{1'b0}}, i_pixel} * {{rrps_pkg::PWR_W{1'b0}}, w_diff};
            r_lo   <= w_lo;
            r_max  <= i_cfg.pwr_full;
            r_thr  <= i_cfg.visible_threshold;
            r_zero <= (i_pixel == '0) || (i_cfg.pwr_full == '0);
            r_bin  <= i_cfg.binary_mode;
        end
    end

    // Exact floor(x / 255) for any product of two 8-bit values: (x + 1 + (x >> 8)) >> 8.
    assign w_q_sum = {1'b0, r_prod} + (2*rrps_pkg::PWR_W+1)'(1)
                   + {{(rrps_pkg::PWR_W+1){1'b0}}, r_prod[2*rrps_pkg::PWR_W-1 -: rrps_pkg::PWR_W]};
    assign w_quot  = w_q_sum[2*rrps_pkg::PWR_W-1 -: rrps_pkg::PWR_W];
    assign w_grey  = {1'b0, r_lo} + {1'b0, w_quot};

    // Second step: overrides and the visibility threshold.
    always_comb begin
        if (r_zero) begin
            o_power = '0;
        end else if (r_bin) begin
            o_power = r_max;
        end else if (w_grey < {1'b0, r_thr}) begin
            o_power = '0;
        end else begin
            o_power = w_grey[rrps_pkg::PWR_W-1:0];
        end
    end

endmodule

### design/raster_row_power_run_segmenter_core.sv
// ----------------------------------------------------------------------------
// raster_row_power_run_segmenter_core
// Maps a row of pixels to laser powers in a row memory, reports the row and
// hands out equal-power runs in travel order, one per fetch request.
// ----------------------------------------------------------------------------
// Usage:
// - i_req carries requests: a load (cmd 0) stores one pixel of the current
//   row, the pixel flagged end_of_row closes the row and yields a summary.
//   A fetch (cmd 1) yields the next run of equal power in travel order.
// - o_rsp carries results; i_cfg writes the five power and mode registers
//   and is always ready. Write it only while no request is in flight.
// - Requests are taken one at a time, only while the block is idle. A load
//   passes through the map multiply, then the row memory write, with any
//   summary loaded into the output register. A fetch reads the row memory
//   once per pixel of the run, through its registered read port, plus one
//   more read when the run ends at a pixel of different power rather than
//   at the last active column of the row. A fetch with nothing pending
//   answers with a fault.
// - Results go into an output register; a new request is taken while a
//   result waits there, and the block holds its next result until the
//   receiver takes the waiting one.
// - Reset clears the row bookkeeping and loads the register defaults. The
//   row memory is not cleared; only written columns are ever read.
// ----------------------------------------------------------------------------
module raster_row_power_run_segmenter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rrps_req_if.sink            i_req,
    rrps_rsp_if.source          o_rsp,
    rrps_cfg_if.sink            i_cfg
);

    localparam int COL_W = rrps_pkg::COL_W;
    localparam int CNT_W = rrps_pkg::CNT_W;
    localparam int PWR_W = rrps_pkg::PWR_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_FIRST = 6'b000100,
        S_WALK  = 6'b001000,
        S_SEG   = 6'b010000,
        S_FLT   = 6'b100000
    } t_state;

    // Control and bookkeeping registers.
    t_state               r_state,   n_state;
    rrps_pkg::t_cfg       r_cfg;
    logic [CNT_W-1:0]     r_fill,    n_fill;
    logic [CNT_W-1:0]     r_first,   n_first;
    logic [COL_W-1:0]     r_last,    n_last;
    logic [CNT_W-1:0]     r_walk,    n_walk;
    logic                 r_rev,     n_rev;
    logic                 r_pending, n_pending;
    logic                 r_out_valid, n_out_valid;

    // Payload registers.
    logic                 r_eor,  n_eor;
    logic                 r_odd,  n_odd;
    logic [PWR_W-1:0]     r_pw,   n_pw;
    logic [COL_W-1:0]     r_end,  n_end;
    logic [COL_W-1:0]     r_next, n_next;
    rrps_pkg::t_rsp       r_out,  n_out;

    // Row memory and its read port.
    logic [PWR_W-1:0]     r_row_mem [rrps_pkg::MAX_ROW_PIXELS];
    logic [PWR_W-1:0]     r_rdata;
    logic [COL_W-1:0]     w_rd_addr;
    logic                 w_we;

    logic                 w_req_acc;
    logic                 w_out_free;
    logic                 w_map_en;
    logic [PWR_W-1:0]     w_power;

    // Load path values.
    logic                 w_new_row;
    logic                 w_ovf;
    logic [CNT_W-1:0]     w_base_first;
    logic [COL_W-1:0]     w_base_last;
    logic [CNT_W-1:0]     w_ld_first;
    logic [COL_W-1:0]     w_ld_last;
    logic                 w_empty;
    logic                 w_ld_rev;
    logic                 w_ld_emit;
    logic [CNT_W-1:0]     w_sum_col;

    // Walk path values.
    logic                 w_bnd_walk;
    logic                 w_bnd_next;
    logic                 w_bnd_end;
    logic [CNT_W-1:0]     w_span;

    // True when a column is the last active one of the row in travel order.
    function automatic logic f_at_bound(input logic [COL_W-1:0] col,
                                        input logic rev,
                                        input logic [CNT_W-1:0] first,
                                        input logic [COL_W-1:0] last);
        logic res;
        if (rev) begin
            res = ({1'b0, col} <= first);
        end else begin
            res = (col >= last);
        end
        return res;
    endfunction

    // Next column in travel order.
    function automatic logic [COL_W-1:0] f_step(input logic [COL_W-1:0] col,
                                                input logic rev);
        logic [COL_W-1:0] res;
        if (rev) begin
            res = col - COL_W'(1);
        end else begin
            res = col + COL_W'(1);
        end
        return res;
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_map_en    = w_req_acc && (i_req.cmd == rrps_pkg::CMD_LOAD);

    // Pixel to power mapping.
    rrps_power_map u_map (
        .i_clk   (i_clk),
        .i_en    (w_map_en),
        .i_pixel (i_req.pixel),
        .i_cfg   (r_cfg),
        .o_power (w_power)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwr_floor         <= '0;
            r_cfg.pwr_full          <= 8'd255;
            r_cfg.binary_mode       <= 1'b0;
            r_cfg.serpentine_mode   <= 1'b0;
            r_cfg.visible_threshold <= 8'd4;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rrps_pkg::CFG_PWR_FLOOR:   r_cfg.pwr_floor         <= i_cfg.data;
                rrps_pkg::CFG_PWR_FULL:    r_cfg.pwr_full          <= i_cfg.data;
                rrps_pkg::CFG_BINARY_MODE: r_cfg.binary_mode       <= i_cfg.data[0];
                rrps_pkg::CFG_SERPENTINE:  r_cfg.serpentine_mode   <= i_cfg.data[0];
                rrps_pkg::CFG_THRESHOLD:   r_cfg.visible_threshold <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Row bookkeeping for the pixel being stored.
    always_comb begin
        w_new_row    = (r_fill == '0);
        w_ovf        = r_fill[COL_W];
        w_base_first = w_new_row ? rrps_pkg::ROW_NONE : r_first;
        w_base_last  = w_new_row ? '0 : r_last;
        w_ld_first   = w_base_first;
        w_ld_last    = w_base_last;
        if (!w_ovf && (w_power != '0)) begin
            if (w_base_first[COL_W]) begin
                w_ld_first = r_fill;
            end
            w_ld_last = r_fill[COL_W-1:0];
        end
        w_empty   = w_ld_first[COL_W];
        w_ld_rev  = r_cfg.serpentine_mode && r_odd;
        w_ld_emit = r_eor || w_ovf;
        if (w_empty) begin
            w_sum_col = '0;
        end else if (w_ld_rev) begin
            w_sum_col = {1'b0, w_ld_last} + CNT_W'(1);
        end else begin
            w_sum_col = w_ld_first;
        end
    end

    // Run boundaries and length.
    always_comb begin
        w_bnd_walk = f_at_bound(r_walk[COL_W-1:0], r_rev, r_first, r_last);
        w_bnd_next = f_at_bound(r_next, r_rev, r_first, r_last);
        w_bnd_end  = f_at_bound(r_end, r_rev, r_first, r_last);
        if (r_rev) begin
            w_span = {1'b0, r_walk[COL_W-1:0]} - {1'b0, r_end} + CNT_W'(1);
        end else begin
            w_span = {1'b0, r_end} - {1'b0, r_walk[COL_W-1:0]} + CNT_W'(1);
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_first     = r_first;
        n_last      = r_last;
        n_walk      = r_walk;
        n_rev       = r_rev;
        n_pending   = r_pending;
        n_eor       = r_eor;
        n_odd       = r_odd;
        n_pw        = r_pw;
        n_end       = r_end;
        n_next      = r_next;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_rd_addr   = r_walk[COL_W-1:0];
        w_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_eor = i_req.end_of_row;
                    n_odd = i_req.odd_row;
                    if (i_req.cmd == rrps_pkg::CMD_LOAD) begin
                        n_state = S_LOAD;
                    end else if (!r_pending || r_walk[COL_W] || r_first[COL_W]) begin
                        n_state = S_FLT;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end

            // Store the mapped pixel and report the row when it closes or overflows.
            S_LOAD: begin
                if (!w_ld_emit || w_out_free) begin
                    w_we    = !w_ovf;
                    n_first = w_ld_first;
                    n_last  = w_ld_last;
                    if (w_new_row) begin
                        n_pending = 1'b0;
                    end
                    if (r_eor) begin
                        n_fill    = '0;
                        n_rev     = w_ld_rev;
                        n_pending = !w_empty;
                        n_walk    = w_ld_rev ? {1'b0, w_ld_last} : w_ld_first;
                    end else if (!w_ovf) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                    if (w_ld_emit) begin
                        n_out       = '0;
                        n_out.kind  = rrps_pkg::KIND_SUMMARY;
                        n_out.fault = w_ovf;
                        if (r_eor) begin
                            n_out.row_empty    = w_empty;
                            n_out.reverse_dir  = w_ld_rev;
                            n_out.start_column = w_sum_col;
                        end
                        n_out_valid = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end

            // First pixel of the run is back from the row memory.
            S_FIRST: begin
                n_pw  = r_rdata;
                n_end = r_walk[COL_W-1:0];
                if (w_bnd_walk) begin
                    n_state = S_SEG;
                end else begin
                    n_next    = f_step(r_walk[COL_W-1:0], r_rev);
                    w_rd_addr = n_next;
                    n_state   = S_WALK;
                end
            end

            // Extend the run while the next pixel has the same power.
            S_WALK: begin
                if (r_rdata == r_pw) begin
                    n_end = r_next;
                    if (w_bnd_next) begin
                        n_state = S_SEG;
                    end else begin
                        n_next    = f_step(r_next, r_rev);
                        w_rd_addr = n_next;
                    end
                end else begin
                    n_state = S_SEG;
                end
            end

            // Hand out the run and move the walk past it.
            S_SEG: begin
                if (w_out_free) begin
                    n_out               = '0;
                    n_out.kind          = rrps_pkg::KIND_SEGMENT;
                    n_out.reverse_dir   = r_rev;
                    n_out.start_column  = r_walk;
                    n_out.span_pixels   = w_span;
                    n_out.run_power     = r_pw;
                    n_out.final_segment = w_bnd_end;
                    n_out_valid         = 1'b1;
                    if (w_bnd_end) begin
                        n_pending = 1'b0;
                    end else begin
                        n_walk = {1'b0, f_step(r_end, r_rev)};
                    end
                    n_state = S_IDLE;
                end
            end

            // Fetch with nothing pending.
            S_FLT: begin
                if (w_out_free) begin
                    n_out       = '0;
                    n_out.kind  = rrps_pkg::KIND_SEGMENT;
                    n_out.fault = 1'b1;
                    n_out_valid = 1'b1;
                    n_pending   = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_first     <= rrps_pkg::ROW_NONE;
            r_last      <= '0;
            r_walk      <= '0;
            r_rev       <= 1'b0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_first     <= n_first;
            r_last      <= n_last;
            r_walk      <= n_walk;
            r_rev       <= n_rev;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_eor  <= n_eor;
        r_odd  <= n_odd;
        r_pw   <= n_pw;
        r_end  <= n_end;
        r_next <= n_next;
        r_out  <= n_out;
    end

    // Row memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_row_mem[r_fill[COL_W-1:0]] <= w_power;
        end
        r_rdata <= r_row_mem[w_rd_addr];
    end

    // Result channel.
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.kind          = r_out.kind;
    assign o_rsp.row_empty     = r_out.row_empty;
    assign o_rsp.reverse_dir   = r_out.reverse_dir;
    assign o_rsp.start_column  = r_out.start_column;
    assign o_rsp.span_pixels   = r_out.span_pixels;
    assign o_rsp.run_power     = r_out.run_power;
    assign o_rsp.final_segment = r_out.final_segment;
    assign o_rsp.fault         = r_out.fault;

    // Pending runs always belong to a row with an active column.
    a_pending_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> !r_first[COL_W])
        else $error("runs pending without an active column");

    // The walk never reads outside the active columns.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_next >= r_first[COL_W-1:0]) && (r_next <= r_last)))
        else $error("walk read outside the active columns");

    // The row memory is never written past the end of the row.
    a_write_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !r_fill[COL_W])
        else $error("row memory write past the end of the row");

    // A good segment always covers at least one pixel.
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == rrps_pkg::KIND_SEGMENT) && !r_out.fault)
            |-> (r_out.span_pixels != '0))
        else $error("segment with zero length");

endmodule

### test/raster_row_power_run_segmenter_core_tb.sv
// ----------------------------------------------------------------------------
// raster_row_power_run_segmenter_core_tb
// Loads pixel rows and fetches their equal-power runs under several power and
// mode settings. A scoreboard predicts each row summary and segment, and the
// results are compared in order. Both sides idle and stall at random, and one
// phase holds the receiver off until the block backs up into its request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_row_power_run_segmenter_core_tb;

    localparam int PWR_W          = rrps_pkg::PWR_W;
    localparam int CNT_W          = rrps_pkg::CNT_W;
    localparam int CFG_IDX_W      = rrps_pkg::CFG_IDX_W;
    localparam int MAX_ROW_PIXELS = rrps_pkg::MAX_ROW_PIXELS;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LOAD_TAIL      = 8;
    localparam int PHASE_ITEMS    = 30;
    localparam int MAX_PRINTS     = 50;

    // One request as the sender offers it.
    typedef struct packed {
        logic             cmd;
        logic [PWR_W-1:0] pixel;
        logic             end_of_row;
        logic             odd_row;
    } t_req_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rrps_req_if req_if ();
    rrps_rsp_if rsp_if ();
    rrps_cfg_if cfg_if ();

    raster_row_power_run_segmenter_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Requests waiting to be offered and results waiting to arrive.
    t_req_item        pending_reqs[$];
    rrps_pkg::t_rsp   expected_results[$];

    int unsigned queued_count;
    int unsigned accepted_count;
    int unsigned result_count;
    int unsigned summary_count;
    int unsigned segment_count;
    int unsigned fault_count;
    int unsigned mismatch_count;
    int unsigned setting_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned idle_cycles;

    // Scoreboard copy of the registers and the row bookkeeping.
    rrps_pkg::t_cfg   pwr_cfg;
    logic [PWR_W-1:0] row_pwr [MAX_ROW_PIXELS];
    int unsigned      fill_cnt;
    int unsigned      first_col;
    int unsigned      last_col;
    int unsigned      walk_col;
    bit               row_rev;
    bit               seg_pending;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Power mapping and row prediction
    // ------------------------------------------------------------------------

    function automatic logic [PWR_W-1:0] map_power(logic [PWR_W-1:0] px);
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        if (px == 0 || pwr_cfg.pwr_full == 0) return '0;
        if (pwr_cfg.binary_mode) return pwr_cfg.pwr_full;
        lo = (pwr_cfg.pwr_floor < pwr_cfg.pwr_full) ? pwr_cfg.pwr_floor : pwr_cfg.pwr_full;
        hi = (pwr_cfg.pwr_floor < pwr_cfg.pwr_full) ? pwr_cfg.pwr_full : pwr_cfg.pwr_floor;
        v  = lo + (int'(px) * (hi - lo)) / 255;
        if (v < pwr_cfg.visible_threshold) v = 0;
        return v[PWR_W-1:0];
    endfunction

    task automatic reset_power_model();
        fill_cnt    = 0;
        first_col   = MAX_ROW_PIXELS;
        last_col    = 0;
        walk_col    = 0;
        row_rev     = 1'b0;
        seg_pending = 1'b0;
        pwr_cfg     = '{pwr_floor: 8'd0, pwr_full: 8'd255, binary_mode: 1'b0,
                        serpentine_mode: 1'b0, visible_threshold: 8'd4};
    endtask

    // Returns 1 when the request yields a result, which is placed in res.
    function automatic bit predict_request(t_req_item rq, output rrps_pkg::t_rsp res);
        bit               overflow;
        bit               empty;
        bit               rev;
        bit               fin;
        logic [PWR_W-1:0] pw;
        int unsigned      start;
        int unsigned      stop;
        res      = '0;
        overflow = 1'b0;
        if (rq.cmd == rrps_pkg::CMD_LOAD) begin
            // A load into an empty row starts over and drops leftover runs.
            if (fill_cnt == 0) begin
                first_col   = MAX_ROW_PIXELS;
                last_col    = 0;
                seg_pending = 1'b0;
            end
            if (fill_cnt >= MAX_ROW_PIXELS) begin
                overflow = 1'b1;
            end else begin
                pw = map_power(rq.pixel);
                row_pwr[fill_cnt] = pw;
                if (pw != 0) begin
                    if (first_col >= MAX_ROW_PIXELS) first_col = fill_cnt;
                    last_col = fill_cnt;
                end
                fill_cnt++;
            end
            if (!rq.end_of_row) begin
                res.kind  = rrps_pkg::KIND_SUMMARY;
                res.fault = 1'b1;
                return overflow;
            end
            // Closing the row reports where travel starts.
            empty = first_col >= MAX_ROW_PIXELS;
            rev   = pwr_cfg.serpentine_mode && rq.odd_row;
            res.kind         = rrps_pkg::KIND_SUMMARY;
            res.row_empty    = empty;
            res.reverse_dir  = rev;
            res.start_column = empty ? '0 : CNT_W'(rev ? last_col + 1 : first_col);
            res.fault        = overflow;
            row_rev     = rev;
            seg_pending = !empty;
            walk_col    = rev ? last_col : first_col;
            fill_cnt    = 0;
            return 1'b1;
        end

        res.kind = rrps_pkg::KIND_SEGMENT;
        if (!seg_pending || walk_col >= MAX_ROW_PIXELS || last_col >= MAX_ROW_PIXELS ||
            first_col >= MAX_ROW_PIXELS) begin
            seg_pending = 1'b0;
            res.fault   = 1'b1;
            return 1'b1;
        end
        // Walk the run of equal power in travel order.
        start = walk_col;
        stop  = start;
        pw    = row_pwr[start];
        if (row_rev) begin
            while (stop > first_col && row_pwr[stop - 1] == pw) stop--;
            res.span_pixels = CNT_W'(start - stop + 1);
            fin = stop <= first_col;
            if (!fin) walk_col = stop - 1;
        end else begin
            while (stop < last_col && row_pwr[stop + 1] == pw) stop++;
            res.span_pixels = CNT_W'(stop - start + 1);
            fin = stop >= last_col;
            if (!fin) walk_col = stop + 1;
        end
        if (fin) seg_pending = 1'b0;
        res.reverse_dir   = row_rev;
        res.start_column  = CNT_W'(start);
        res.run_power     = pw;
        res.final_segment = fin;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      result_count, name, got, want));
    endtask

    // Sees every handshake: checks results, predicts requests, tracks registers.
    always @(posedge i_clk) begin : scoreboard
        rrps_pkg::t_rsp got;
        rrps_pkg::t_rsp want;
        t_req_item      rq;
        if (!i_rst_n) begin
            reset_power_model();
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{kind: rsp_if.kind, row_empty: rsp_if.row_empty,
                        reverse_dir: rsp_if.reverse_dir, start_column: rsp_if.start_column,
                        span_pixels: rsp_if.span_pixels, run_power: rsp_if.run_power,
                        final_segment: rsp_if.final_segment, fault: rsp_if.fault};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_count));
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", CNT_W'(got.kind), CNT_W'(want.kind));
                    check_field("row_empty", CNT_W'(got.row_empty), CNT_W'(want.row_empty));
                    check_field("reverse_dir", CNT_W'(got.reverse_dir),
                                CNT_W'(want.reverse_dir));
                    check_field("start_column", got.start_column, want.start_column);
                    check_field("span_pixels", got.span_pixels, want.span_pixels);
                    check_field("run_power", CNT_W'(got.run_power), CNT_W'(want.run_power));
                    check_field("final_segment", CNT_W'(got.final_segment),
                                CNT_W'(want.final_segment));
                    check_field("fault", CNT_W'(got.fault), CNT_W'(want.fault));
                    if (want.fault) fault_count++;
                    else if (want.kind == rrps_pkg::KIND_SUMMARY) summary_count++;
                    else segment_count++;
                end
                result_count++;
            end
            if (req_if.valid && req_if.ready) begin
                rq = '{cmd: req_if.cmd, pixel: req_if.pixel,
                       end_of_row: req_if.end_of_row, odd_row: req_if.odd_row};
                if (predict_request(rq, want)) expected_results = {expected_results, want};
                accepted_count++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    rrps_pkg::CFG_PWR_FLOOR:   pwr_cfg.pwr_floor         = cfg_if.data;
                    rrps_pkg::CFG_PWR_FULL:    pwr_cfg.pwr_full          = cfg_if.data;
                    rrps_pkg::CFG_BINARY_MODE: pwr_cfg.binary_mode       = cfg_if.data[0];
                    rrps_pkg::CFG_SERPENTINE:  pwr_cfg.serpentine_mode   = cfg_if.data[0];
                    rrps_pkg::CFG_THRESHOLD:   pwr_cfg.visible_threshold = cfg_if.data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver, result receiver and watchdog
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : request_driver
        t_req_item nxt;
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.cmd        <= rrps_pkg::CMD_LOAD;
            req_if.pixel      <= '0;
            req_if.end_of_row <= 1'b0;
            req_if.odd_row    <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_if.valid      <= 1'b1;
                req_if.cmd        <= nxt.cmd;
                req_if.pixel      <= nxt.pixel;
                req_if.end_of_row <= nxt.end_of_row;
                req_if.odd_row    <= nxt.odd_row;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // A new hold request starts a long stretch with ready low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                     (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("raster_row_power_run_segmenter_core_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_req(logic cmd, logic [PWR_W-1:0] px, logic eor, logic odd);
        t_req_item item;
        item = '{cmd: cmd, pixel: px, end_of_row: eor, odd_row: odd};
        pending_reqs = {pending_reqs, item};
        queued_count++;
    endtask

    // The fields other than the command do not matter to a fetch.
    task automatic queue_fetch();
        queue_req(rrps_pkg::CMD_FETCH, PWR_W'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    // Number of equal-power runs the current settings make of a row.
    function automatic int count_runs(input logic [PWR_W-1:0] px []);
        int               n;
        int               first;
        int               last;
        int               runs;
        logic [PWR_W-1:0] p;
        logic [PWR_W-1:0] prev;
        n     = (px.size() < MAX_ROW_PIXELS) ? px.size() : MAX_ROW_PIXELS;
        first = -1;
        last  = -1;
        for (int i = 0; i < n; i++) begin
            if (map_power(px[i]) != 0) begin
                if (first < 0) first = i;
                last = i;
            end
        end
        if (first < 0) return 0;
        runs = 1;
        prev = map_power(px[first]);
        for (int i = first + 1; i <= last; i++) begin
            p = map_power(px[i]);
            if (p != prev) runs++;
            prev = p;
        end
        return runs;
    endfunction

    // Loads one row built from short runs and mostly fetches all of its
    // segments; sometimes one fetch too many, sometimes it stops early.
    task automatic queue_row(int len, logic odd, bit flat);
        logic [PWR_W-1:0] px [];
        logic [PWR_W-1:0] v;
        int               i;
        int               rep;
        int               r;
        int               runs;
        int               fetches;
        px = new[len];
        i  = 0;
        while (i < len) begin
            r = $urandom_range(9);
            if (flat || r == 2) v = 8'd255;
            else if (r < 2) v = 8'd0;
            else if (r == 3) v = PWR_W'($urandom_range(1, 7));
            else v = PWR_W'($urandom_range(255));
            rep = $urandom_range(1, 6);
            for (int k = 0; k < rep && i < len; k++) begin
                px[i] = v;
                i++;
            end
        end
        for (i = 0; i < len; i++) queue_req(rrps_pkg::CMD_LOAD, px[i], i == len - 1, odd);
        runs = count_runs(px);
        r    = $urandom_range(19);
        if (flat || r < 16) fetches = runs;
        else if (r < 18) fetches = runs + 1;
        else fetches = $urandom_range(runs);
        repeat (fetches) queue_fetch();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PWR_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Mode bits ride in bit 0; the upper data bits are noise.
    task automatic write_config(rrps_pkg::t_cfg c);
        write_reg(rrps_pkg::CFG_PWR_FLOOR, c.pwr_floor);
        write_reg(rrps_pkg::CFG_PWR_FULL, c.pwr_full);
        write_reg(rrps_pkg::CFG_BINARY_MODE, {7'($urandom_range(127)), c.binary_mode});
        write_reg(rrps_pkg::CFG_SERPENTINE, {7'($urandom_range(127)), c.serpentine_mode});
        write_reg(rrps_pkg::CFG_THRESHOLD, c.visible_threshold);
        setting_count++;
    endtask

    // Waits until every request is in and answered, then lets the last
    // silent load finish.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (accepted_count != queued_count || expected_results.size() != 0);
        repeat (LOAD_TAIL) @(posedge i_clk);
    endtask

    initial begin : stimulus
        rrps_pkg::t_cfg c;
        int unsigned    target;
        int             r;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = rrps_pkg::CFG_PWR_FLOOR;
        cfg_if.data       = '0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_req          = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings. Fetch with nothing loaded.
        queue_fetch();
        // Full and faint pixels, a run of two and a zero gap inside the row,
        // then one fetch past the end of the row.
        queue_req(rrps_pkg::CMD_LOAD, 8'd0, 1'b0, 1'b0);
        queue_req(rrps_pkg::CMD_LOAD, 8'd255, 1'b0, 1'b0);
        queue_req(rrps_pkg::CMD_LOAD, 8'd255, 1'b0, 1'b0);
        queue_req(rrps_pkg::CMD_LOAD, 8'd1, 1'b0, 1'b0);
        queue_req(rrps_pkg::CMD_LOAD, 8'd128, 1'b0, 1'b0);
        queue_req(rrps_pkg::CMD_LOAD, 8'd0, 1'b1, 1'b0);
        repeat (4) queue_fetch();
        // A row that falls entirely under the threshold is empty.
        queue_req(rrps_pkg::CMD_LOAD, 8'd0, 1'b0, 1'b1);
        queue_req(rrps_pkg::CMD_LOAD, 8'd3, 1'b1, 1'b1);
        queue_fetch();
        // Single-pixel row on an odd line without serpentine travel.
        queue_req(rrps_pkg::CMD_LOAD, 8'd200, 1'b1, 1'b1);
        queue_fetch();
        // A new row drops the runs still pending from the last one.
        queue_req(rrps_pkg::CMD_LOAD, 8'd9, 1'b0, 1'b0);
        queue_req(rrps_pkg::CMD_LOAD, 8'd8, 1'b1, 1'b0);
        queue_fetch();
        queue_req(rrps_pkg::CMD_LOAD, 8'h55, 1'b1, 1'b0);
        queue_fetch();
        wait_drained();

        // Random phases, each with its own settings and idling pattern.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: c = '{8'd0, 8'd255, 1'b0, 1'b1, 8'd4};
                1: c = '{8'd200, 8'd50, 1'b0, 1'b1, 8'd0};
                2: c = '{8'd10, 8'd255, 1'b1, 1'b1, 8'd255};
                3: c = '{8'd0, 8'd0, 1'b0, 1'b1, 8'd4};
                4: c = '{8'd0, 8'd255, 1'b0, 1'b0, 8'd255};
                5: c = '{8'd255, 8'd255, 1'b0, 1'b1, 8'd0};
                default: c = '{PWR_W'($urandom_range(255)), PWR_W'($urandom_range(1, 255)),
                               1'($urandom_range(3) == 0), 1'($urandom_range(3) != 0),
                               PWR_W'($urandom_range(40))};
            endcase
            write_config(c);
            // Indexes past the last register must be ignored.
            if (ph == 3) begin
                for (int idx = int'(rrps_pkg::CFG_THRESHOLD) + 1; idx < 2 ** CFG_IDX_W;
                     idx++)
                    write_reg(CFG_IDX_W'(idx), PWR_W'($urandom_range(255)));
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            target = queued_count + ((c.pwr_full == 0) ? 60 : PHASE_ITEMS);
            while (queued_count < target) begin
                r = $urandom_range(19);
                if (r < 2) begin
                    repeat ($urandom_range(1, 3)) queue_fetch();
                end else begin
                    r = $urandom_range(19);
                    if (r < 14) queue_row($urandom_range(1, 16), 1'($urandom_range(1)), 1'b0);
                    else if (r < 19) queue_row($urandom_range(17, 64), 1'($urandom_range(1)), 1'b0);
                    else queue_row($urandom_range(65, 300), 1'($urandom_range(1)), 1'b0);
                end
            end
            wait_drained();
        end

        // Overflowing reverse row of full pixels: one run across the whole row.
        write_config('{8'd0, 8'd255, 1'b0, 1'b1, 8'd4});
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_row(MAX_ROW_PIXELS + 2, 1'b1, 1'b1);
        wait_drained();

        // Receiver holds off while every request keeps producing results.
        hold_req++;
        repeat (20) begin
            queue_req(rrps_pkg::CMD_LOAD, PWR_W'($urandom_range(255)), 1'b1,
                      1'($urandom_range(1)));
            queue_fetch();
        end
        wait_drained();

        $display("Covered %0d requests and %0d results: %0d row summaries,",
                 accepted_count, result_count, summary_count);
        $display("%0d segments and %0d faults over %0d register settings.",
                 segment_count, fault_count, setting_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("raster_row_power_run_segmenter_core_tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_results.size());
            $display("raster_row_power_run_segmenter_core_tb NOT OK");
        end
        $finish;
    end

endmodule
